// ===== design/crcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, constants and CRC-16/IBM helpers for the frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  // default body counter width
  localparam int COUNT_WIDTH_DEF = 16;

  // register widths and reset values
  localparam int HDR_W = 32;
  localparam int MAXLEN_W = 16;
  localparam int LEN_W = 32;
  localparam int BLEN_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam logic [HDR_W-1:0] HEADER_WORD_RST = 32'hBBAC_CAAA;
  localparam logic [MAXLEN_W-1:0] MAX_DATA_LEN_RST = 16'd1024;

  // crc-16/ibm, reflected form
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // flags, command and crc take four bytes of the data length
  localparam logic [LEN_W-1:0] LEN_OVERHEAD = 32'd4;

  // register indexes
  typedef enum logic [0:0] {
    REG_HEADER_WORD  = 1'b0,
    REG_MAX_DATA_LEN = 1'b1
  } reg_index_t;

  // result item kinds
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // end item status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  // configuration seen by the frame logic
  typedef struct packed {
    logic [HDR_W-1:0]    header_word;
    logic [MAXLEN_W-1:0] max_data_len;
    logic [15:0]         header_crc;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [7:0]        body_byte;
    logic [7:0]        flags_byte;
    logic [7:0]        command;
    logic [BLEN_W-1:0] body_length;
    logic [1:0]        status;
  } res_t;

  // one byte through the crc, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // crc of a 32-bit word sent least significant byte first
  function automatic logic [15:0] crc16_word(input logic [HDR_W-1:0] w);
    logic [15:0] c;
    c = CRC_INIT;
    for (int k = 0; k < 4; k++) begin
      c = crc16_byte(c, w[8*k +: 8]);
    end
    return c;
  endfunction

endpackage

// ===== design/crcdf_in_reg.sv =====
// ----------------------------------------------------------------------------
// crcdf_in_reg
// Input register for received bytes; holds an item until the frame logic
// takes it, and refills in the same cycle.
// ----------------------------------------------------------------------------
module crcdf_in_reg import crcdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic accept;

  // stall only while a held item is not being taken
  assign in_stall = held_valid && !take;
  assign accept = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== design/crcdf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crcdf_cfg_regs
// Configuration registers, with the crc of the header word kept alongside
// so that the frame logic can seed its checksum at once.
// ----------------------------------------------------------------------------
module crcdf_cfg_regs import crcdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  reg_index_t idx;

  assign idx = reg_index_t'(cfg_index);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word  <= HEADER_WORD_RST;
      cfg.max_data_len <= MAX_DATA_LEN_RST;
      cfg.header_crc   <= crc16_word(HEADER_WORD_RST);
    end else if (cfg_we) begin
      unique case (idx)
        REG_HEADER_WORD: begin
          cfg.header_word <= cfg_data[HDR_W-1:0];
          cfg.header_crc  <= crc16_word(cfg_data[HDR_W-1:0]);
        end
        REG_MAX_DATA_LEN: begin
          cfg.max_data_len <= cfg_data[MAXLEN_W-1:0];
        end
        default: begin
          cfg.max_data_len <= cfg.max_data_len;
        end
      endcase
    end
  end

endmodule

// ===== design/crcdf_step.sv =====
// ----------------------------------------------------------------------------
// crcdf_step
// Frame state and per-byte logic: header hunt, length, flags, command, body
// and crc check, producing at most one result item per byte.
// ----------------------------------------------------------------------------
module crcdf_step import crcdf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_FLAGS = 7'b0000100,
    PH_CMD   = 7'b0001000,
    PH_BODY  = 7'b0010000,
    PH_CRCLO = 7'b0100000,
    PH_CRCHI = 7'b1000000
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_FOUR = COUNT_WIDTH'(4);

  phase_t                 phase, phase_next;
  logic [HDR_W-1:0]       header_window, header_window_next;
  logic [LEN_W-1:0]       length_shift, length_shift_next;
  logic [COUNT_WIDTH-1:0] byte_countdown, byte_countdown_next;
  logic [15:0]            crc_accum, crc_accum_next;
  logic [7:0]             held_flags, held_flags_next;
  logic [7:0]             held_command, held_command_next;
  logic [7:0]             crc_low_byte, crc_low_byte_next;

  logic [15:0]            crc_upd;
  logic [LEN_W-1:0]       len_new;
  logic [LEN_W-1:0]       body_len_full;
  logic [HDR_W-1:0]       win_new;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] cnt_hunt;
  logic [15:0]            crc_got;

  // shared datapath terms
  assign crc_upd = crc16_byte(crc_accum, item_byte);
  assign len_new = {item_byte, length_shift[LEN_W-1:8]};
  assign win_new = {item_byte, header_window[HDR_W-1:8]};
  assign body_len_full = length_shift - LEN_OVERHEAD;
  assign cnt_inc = byte_countdown + CNT_ONE;
  assign cnt_dec = byte_countdown - CNT_ONE;
  assign cnt_hunt = (byte_countdown < CNT_FOUR) ? cnt_inc : byte_countdown;
  assign crc_got = {item_byte, crc_low_byte};

  // next state and result
  always_comb begin
    phase_next          = phase;
    header_window_next  = header_window;
    length_shift_next   = length_shift;
    byte_countdown_next = byte_countdown;
    crc_accum_next      = crc_accum;
    held_flags_next     = held_flags;
    held_command_next   = held_command;
    crc_low_byte_next   = crc_low_byte;
    res_valid           = 1'b0;
    res                 = '0;
    if (item_valid) begin
      unique case (phase)
        PH_LEN: begin
          crc_accum_next      = crc_upd;
          length_shift_next   = len_new;
          byte_countdown_next = cnt_inc;
          if (cnt_inc >= CNT_FOUR) begin
            if (len_new < LEN_OVERHEAD ||
                len_new > {{(LEN_W-MAXLEN_W){1'b0}}, cfg.max_data_len}) begin
              // length out of range: report and hunt again
              phase_next          = PH_HUNT;
              header_window_next  = '0;
              byte_countdown_next = CNT_ZERO;
              res_valid           = 1'b1;
              res.kind            = KIND_END;
              res.status          = ST_LEN_ERR;
            end else begin
              byte_countdown_next = CNT_ZERO;
              phase_next          = PH_FLAGS;
            end
          end
        end
        PH_FLAGS: begin
          crc_accum_next  = crc_upd;
          held_flags_next = item_byte;
          phase_next      = PH_CMD;
        end
        PH_CMD: begin
          crc_accum_next      = crc_upd;
          held_command_next   = item_byte;
          byte_countdown_next = body_len_full[COUNT_WIDTH-1:0];
          phase_next = (body_len_full[COUNT_WIDTH-1:0] == CNT_ZERO) ? PH_CRCLO : PH_BODY;
        end
        PH_BODY: begin
          crc_accum_next      = crc_upd;
          byte_countdown_next = cnt_dec;
          if (cnt_dec == CNT_ZERO) begin
            phase_next = PH_CRCLO;
          end
          res_valid     = 1'b1;
          res.kind      = KIND_BODY;
          res.body_byte = item_byte;
        end
        PH_CRCLO: begin
          crc_low_byte_next = item_byte;
          phase_next        = PH_CRCHI;
        end
        PH_CRCHI: begin
          // end of frame: compare received crc
          phase_next          = PH_HUNT;
          header_window_next  = '0;
          byte_countdown_next = CNT_ZERO;
          res_valid           = 1'b1;
          res.kind            = KIND_END;
          res.flags_byte      = held_flags;
          res.command         = held_command;
          res.body_length     = body_len_full[BLEN_W-1:0];
          res.status          = (crc_got == crc_accum) ? ST_OK : ST_CRC_ERR;
        end
        default: begin
          // header hunt, also taken by unused codes
          phase_next          = PH_HUNT;
          header_window_next  = win_new;
          byte_countdown_next = cnt_hunt;
          if (cnt_hunt >= CNT_FOUR && win_new == cfg.header_word) begin
            crc_accum_next      = cfg.header_crc;
            length_shift_next   = '0;
            byte_countdown_next = CNT_ZERO;
            phase_next          = PH_LEN;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_window  <= '0;
      length_shift   <= '0;
      byte_countdown <= CNT_ZERO;
      crc_accum      <= CRC_INIT;
      held_flags     <= '0;
      held_command   <= '0;
      crc_low_byte   <= '0;
    end else begin
      phase          <= phase_next;
      header_window  <= header_window_next;
      length_shift   <= length_shift_next;
      byte_countdown <= byte_countdown_next;
      crc_accum      <= crc_accum_next;
      held_flags     <= held_flags_next;
      held_command   <= held_command_next;
      crc_low_byte   <= crc_low_byte_next;
    end
  end

endmodule

// ===== design/crcdf_out_buf.sv =====
// ----------------------------------------------------------------------------
// crcdf_out_buf
// Two-entry result buffer; the head entry drives the output channel and the
// second entry absorbs an item produced while the output is stalled.
// ----------------------------------------------------------------------------
module crcdf_out_buf import crcdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_item,
  output logic room,
  output logic out_valid,
  input  logic out_stall,
  output res_t head
);

  logic [1:0] count;
  res_t       tail;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign room = (count != 2'd2);
  assign pop = out_valid && !out_stall;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (push) begin
        head <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_item;
      end else begin
        tail <= push_item;
      end
    end
  end

endmodule

// ===== design/crc16_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Byte-stream deframer: header hunt, length check, body pass-through and
// CRC-16/IBM check of each frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle, sustained, as long as
// results are taken. Each byte is held in an input register and handled by
// the frame logic once the result buffer has room; any result it causes (a
// body byte or an end-of-frame status) is registered into the result buffer,
// which drives the output. The rate is set by the single frame-state update
// per byte, whose CRC step is one unrolled byte update. A two-entry result
// buffer lets input keep flowing while the output is stalled, until its
// second entry fills. Configuration writes take effect from the next byte.
// ----------------------------------------------------------------------------
module crc16_frame_deframer import crcdf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [7:0]            body_byte,
  output logic [7:0]            flags_byte,
  output logic [7:0]            command,
  output logic [BLEN_W-1:0]     body_length,
  output logic [1:0]            status
);

  cfg_t       cfg;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       room;
  logic       take;
  logic       res_valid;
  res_t       res;
  res_t       head;

  // a held byte is processed whenever the result buffer has space
  assign take = held_valid && room;

  crcdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crcdf_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  crcdf_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (take),
    .item_byte  (held_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  crcdf_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_item (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields
  assign kind        = head.kind;
  assign body_byte   = head.body_byte;
  assign flags_byte  = head.flags_byte;
  assign command     = head.command;
  assign body_length = head.body_length;
  assign status      = head.status;

endmodule
